// ===== design/pce_pkg.sv =====
// Package for the packet checksum encoder: widths, header positions, word types.
package pce_pkg;

  // Payload buffer depth and derived widths
  localparam int MAX_PAYLOAD = 256;
  localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int HDR_BYTES   = 4;
  localparam int POS_W       = $clog2(MAX_PAYLOAD + HDR_BYTES + 2);

  // Header positions within the encoded packet
  localparam int POS_CODE    = 0;
  localparam int POS_LEN_LO  = 1;
  localparam int POS_LEN_HI  = 2;
  localparam int POS_RKEY    = 3;
  localparam int POS_CSUM    = HDR_BYTES;
  localparam int POS_DATA    = HDR_BYTES + 1;

  localparam logic [7:0] RANDOM_KEY_RST = 8'h31;

  // Request codes
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_PULL = 1'b1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_STATIC_KEY  = 2'd0,
    CFG_RANDOM_KEY  = 2'd1,
    CFG_PACKET_CODE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } out_word_t;

  // Buffer access from the encoder
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } buf_req_t;

  typedef struct packed {
    logic [7:0] static_key;
    logic [7:0] random_key;
    logic [7:0] packet_code;
  } cfg_regs_t;

endpackage

// ===== design/pce_buffer.sv =====
// Payload byte buffer: one write port, one registered read port.
module pce_buffer
  import pce_pkg::*;
(
  input  logic       clk_i,
  input  buf_req_t   req_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem [MAX_PAYLOAD];
  logic [7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/pce_encoder.sv =====
// Packet state, checksum and two-stage rolling xor encoding of the checksum and payload bytes.
module pce_encoder
  import pce_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  in_word_t   word_i,
  input  cfg_regs_t  cfg_i,
  input  logic [7:0] rdata_i,
  output buf_req_t   buf_o,
  output logic       res_en_o,
  output out_word_t  res_o
);

  logic [CNT_W-1:0] fill_q, fill_d;
  logic [7:0]       sum_q, sum_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             frozen_q, frozen_d;
  logic [7:0]       s1_q, s1_d;
  logic [7:0]       s2_q, s2_d;

  logic [POS_W-1:0] pos_cur;
  logic [POS_W-1:0] last_pos;
  logic [7:0]       s1_cur, s2_cur;
  logic [7:0]       cnt_i;
  logic [7:0]       src_b;
  logic [7:0]       p_byte, e_byte;
  logic [15:0]      len16;
  logic             is_pull, is_push, empty_pull;

  assign is_pull    = fire_i && (word_i.req_type == REQ_PULL);
  assign is_push    = fire_i && (word_i.req_type == REQ_PUSH);
  assign empty_pull = !frozen_q && (fill_q == '0);

  // position and stage values as seen by this pull (first pull starts afresh)
  assign pos_cur  = frozen_q ? pos_q : '0;
  assign s1_cur   = frozen_q ? s1_q : 8'h00;
  assign s2_cur   = frozen_q ? s2_q : 8'h00;
  assign last_pos = POS_W'(fill_q) + POS_W'(HDR_BYTES);
  assign len16    = 16'(fill_q);

  // rolling xor on checksum or payload byte
  assign cnt_i  = 8'(pos_cur - POS_W'(POS_RKEY));
  assign src_b  = (pos_cur == POS_W'(POS_CSUM)) ? sum_q : rdata_i;
  assign p_byte = src_b ^ 8'(s1_cur + cfg_i.random_key + cnt_i);
  assign e_byte = p_byte ^ 8'(s2_cur + cfg_i.static_key + cnt_i);

  // result word
  always_comb begin
    res_en_o        = is_pull;
    res_o.out_valid = !empty_pull;
    res_o.out_last  = !empty_pull && (pos_cur >= last_pos);
    res_o.out_byte  = 8'h00;
    if (!empty_pull) begin
      if (pos_cur == POS_W'(POS_CODE)) begin
        res_o.out_byte = cfg_i.packet_code;
      end else if (pos_cur == POS_W'(POS_LEN_LO)) begin
        res_o.out_byte = len16[7:0];
      end else if (pos_cur == POS_W'(POS_LEN_HI)) begin
        res_o.out_byte = len16[15:8];
      end else if (pos_cur == POS_W'(POS_RKEY)) begin
        res_o.out_byte = cfg_i.random_key;
      end else begin
        res_o.out_byte = e_byte;
      end
    end
  end

  // next state
  always_comb begin
    fill_d   = fill_q;
    sum_d    = sum_q;
    pos_d    = pos_q;
    frozen_d = frozen_q;
    s1_d     = s1_q;
    s2_d     = s2_q;
    if (is_push && !frozen_q && (fill_q < CNT_W'(MAX_PAYLOAD))) begin
      fill_d = fill_q + CNT_W'(1);
      sum_d  = sum_q + word_i.data_byte;
    end
    if (is_pull && !empty_pull) begin
      if (pos_cur >= last_pos) begin
        // packet done: empty the block
        fill_d   = '0;
        sum_d    = 8'h00;
        pos_d    = '0;
        frozen_d = 1'b0;
        s1_d     = 8'h00;
        s2_d     = 8'h00;
      end else begin
        frozen_d = 1'b1;
        pos_d    = pos_cur + POS_W'(1);
        s1_d     = s1_cur;
        s2_d     = s2_cur;
        if (pos_cur >= POS_W'(POS_CSUM)) begin
          s1_d = p_byte;
          s2_d = e_byte;
        end
      end
    end
  end

  // buffer: write on push, prefetch the byte the next pull will need
  always_comb begin
    buf_o.we    = is_push && !frozen_q && (fill_q < CNT_W'(MAX_PAYLOAD));
    buf_o.waddr = ADDR_W'(fill_q);
    buf_o.wdata = word_i.data_byte;
    buf_o.raddr = ADDR_W'(pos_d - POS_W'(POS_DATA));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      sum_q    <= 8'h00;
      pos_q    <= '0;
      frozen_q <= 1'b0;
      s1_q     <= 8'h00;
      s2_q     <= 8'h00;
    end else begin
      fill_q   <= fill_d;
      sum_q    <= sum_d;
      pos_q    <= pos_d;
      frozen_q <= frozen_d;
      s1_q     <= s1_d;
      s2_q     <= s2_d;
    end
  end

  // checks
  a_pos_in_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(fill_q) + POS_W'(HDR_BYTES))
    else $error("emit position beyond end of packet");

  a_loading_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !frozen_q |-> (pos_q == '0))
    else $error("emit position moved while loading");

  a_frozen_fill_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frozen_q && frozen_d) |=> $stable(fill_q) && $stable(sum_q))
    else $error("buffer changed during a frozen packet");

  a_frozen_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frozen_q |-> (fill_q != '0))
    else $error("frozen with an empty buffer");

endmodule

// ===== design/packet_checksum_xor_chain_encoder.sv =====
// Top level of the packet checksum encoder: ports, config registers, result register.
//
//  channel | valid      | ready       | word
//  --------+------------+-------------+--------------------------------
//  in      | in_valid_i | in_ready_o  | in_data_i  (req_type, data_byte)
//  out     | out_valid_o| out_ready_i | out_data_o (out_byte, valid, last)
//  cfg     | cfg_valid_i| cfg_ready_o | cfg_index_i, cfg_data_i
//
// One word is taken per cycle while in_ready_o is high; a pull gives its result in the output register
// the cycle after it is accepted, a push gives none. Reset empties the buffer
// and loads the key defaults; no clearing pass is needed. in_ready_o drops only
// while a result sits in the output register and out_ready_i is low. Payload
// bytes are prefetched from the buffer's registered read port one pull ahead.
module packet_checksum_xor_chain_encoder
  import pce_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_word_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_word_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  cfg_regs_t  cfg_q;
  logic       out_vld_q, out_vld_d;
  out_word_t  out_q;
  logic       fire;
  logic       res_en;
  out_word_t  res;
  buf_req_t   buf_req;
  logic [7:0] rdata;

  assign in_ready_o  = !out_vld_q || out_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.static_key  <= 8'h00;
      cfg_q.random_key  <= RANDOM_KEY_RST;
      cfg_q.packet_code <= 8'h00;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_STATIC_KEY:  cfg_q.static_key  <= cfg_data_i;
        CFG_RANDOM_KEY:  cfg_q.random_key  <= cfg_data_i;
        CFG_PACKET_CODE: cfg_q.packet_code <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pce_encoder u_encoder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .word_i   (in_data_i),
    .cfg_i    (cfg_q),
    .rdata_i  (rdata),
    .buf_o    (buf_req),
    .res_en_o (res_en),
    .res_o    (res)
  );

  pce_buffer u_buffer (
    .clk_i   (clk_i),
    .req_i   (buf_req),
    .rdata_o (rdata)
  );

  // output register
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (res_en) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_en) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
